// ===== sv/qat_pkg.sv =====
// ----------------------------------------------------------------------------
// qat_pkg: shared types and constants of the argument tokenizer
// Scan mode and result kind codes, the result record and the count clamp.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    // scan modes
    localparam logic [2:0] M_BETWEEN    = 3'd0;
    localparam logic [2:0] M_TOKEN      = 3'd1;
    localparam logic [2:0] M_TOKEN_ESC  = 3'd2;
    localparam logic [2:0] M_RAW        = 3'd3;
    localparam logic [2:0] M_RAW_ESC    = 3'd4;
    localparam logic [2:0] M_COOKED     = 3'd5;
    localparam logic [2:0] M_COOKED_ESC = 3'd6;

    // result kinds
    localparam logic [1:0] K_CHAR       = 2'd0;
    localparam logic [1:0] K_TOKEN_END  = 2'd1;
    localparam logic [1:0] K_STRING_END = 2'd2;
    localparam logic [1:0] K_ERROR      = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_out;
        logic [15:0] token_total;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_t;

    function automatic logic [7:0] cook(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "a":     r = CH_BEL;
            "b":     r = CH_BS;
            "t":     r = CH_TAB;
            "n":     r = CH_LF;
            "v":     r = CH_VT;
            "f":     r = CH_FF;
            "r":     r = CH_CR;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic [15:0] clamp_total(input logic [COUNT_WIDTH-1:0] v);
        logic [TOTAL_EXT_W-1:0] ext;
        ext = TOTAL_EXT_W'(v);
        return (ext > TOTAL_EXT_W'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

endpackage

// ===== sv/qat_if.sv =====
// ----------------------------------------------------------------------------
// qat_if: byte and result channels of the argument tokenizer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qat_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface qat_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  char_out;
    logic [15:0] token_total;
    logic        last;

    modport source (output valid, output kind, output char_out, output token_total,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_out, input token_total,
                    input last, output ready);
endinterface

// ===== sv/qat_step.sv =====
// ----------------------------------------------------------------------------
// qat_step: scanner state and per-byte decode
// Holds scan mode and token count and turns one byte into up to two results.
// ----------------------------------------------------------------------------
module qat_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          byte_in,
    output qat_pkg::step_t      step
);

    logic [2:0]                      mode_reg;
    logic [2:0]                      mode_next;
    logic [qat_pkg::COUNT_WIDTH-1:0] cnt_reg;
    logic [qat_pkg::COUNT_WIDTH-1:0] cnt_next;
    logic [qat_pkg::COUNT_WIDTH-1:0] cnt_emit;
    logic                            use_tok;
    logic [1:0]                      n;
    logic [1:0]                      k0;
    logic [1:0]                      k1;
    logic [7:0]                      ch0;
    logic [7:0]                      ch1;
    logic [15:0]                     total;

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        cnt_emit  = cnt_reg;
        use_tok   = 1'b0;
        n         = 2'd0;
        k0        = qat_pkg::K_CHAR;
        k1        = qat_pkg::K_CHAR;
        ch0       = 8'h00;
        ch1       = 8'h00;

        if (byte_in == qat_pkg::CH_NUL)
        begin
            case (mode_reg)
                qat_pkg::M_TOKEN, qat_pkg::M_TOKEN_ESC:
                begin
                    n  = 2'd2;
                    k0 = qat_pkg::K_TOKEN_END;
                    k1 = qat_pkg::K_STRING_END;
                end
                qat_pkg::M_RAW, qat_pkg::M_RAW_ESC,
                qat_pkg::M_COOKED, qat_pkg::M_COOKED_ESC:
                begin
                    n  = 2'd1;
                    k0 = qat_pkg::K_ERROR;
                end
                default:
                begin
                    n  = 2'd1;
                    k0 = qat_pkg::K_STRING_END;
                end
            endcase
            mode_next = qat_pkg::M_BETWEEN;
            cnt_next  = '0;
        end
        else
        begin
            case (mode_reg)
                qat_pkg::M_TOKEN:
                begin
                    use_tok = 1'b1;
                end
                qat_pkg::M_TOKEN_ESC:
                begin
                    n         = 2'd1;
                    ch0       = byte_in;
                    mode_next = qat_pkg::M_TOKEN;
                end
                qat_pkg::M_RAW:
                begin
                    if (byte_in == qat_pkg::CH_SQUOTE)
                        mode_next = qat_pkg::M_TOKEN;
                    else if (byte_in == qat_pkg::CH_BACKSLASH)
                        mode_next = qat_pkg::M_RAW_ESC;
                    else
                    begin
                        n   = 2'd1;
                        ch0 = byte_in;
                    end
                end
                qat_pkg::M_RAW_ESC:
                begin
                    // unknown escape keeps its backslash
                    if (byte_in != qat_pkg::CH_BACKSLASH && byte_in != qat_pkg::CH_SQUOTE)
                    begin
                        n   = 2'd2;
                        ch0 = qat_pkg::CH_BACKSLASH;
                        ch1 = byte_in;
                    end
                    else
                    begin
                        n   = 2'd1;
                        ch0 = byte_in;
                    end
                    mode_next = qat_pkg::M_RAW;
                end
                qat_pkg::M_COOKED:
                begin
                    if (byte_in == qat_pkg::CH_DQUOTE)
                        mode_next = qat_pkg::M_TOKEN;
                    else if (byte_in == qat_pkg::CH_BACKSLASH)
                        mode_next = qat_pkg::M_COOKED_ESC;
                    else
                    begin
                        n   = 2'd1;
                        ch0 = byte_in;
                    end
                end
                qat_pkg::M_COOKED_ESC:
                begin
                    n         = 2'd1;
                    ch0       = qat_pkg::cook(byte_in);
                    mode_next = qat_pkg::M_COOKED;
                end
                default:
                begin
                    mode_next = qat_pkg::M_BETWEEN;
                    if (!qat_pkg::is_blank(byte_in))
                    begin
                        if (cnt_reg != '1)
                            cnt_next = cnt_reg + qat_pkg::COUNT_WIDTH'(1);
                        cnt_emit  = cnt_next;
                        mode_next = qat_pkg::M_TOKEN;
                        use_tok   = 1'b1;
                    end
                end
            endcase

            if (use_tok)
            begin
                if (byte_in == qat_pkg::CH_BACKSLASH)
                    mode_next = qat_pkg::M_TOKEN_ESC;
                else if (byte_in == qat_pkg::CH_SQUOTE)
                    mode_next = qat_pkg::M_RAW;
                else if (byte_in == qat_pkg::CH_DQUOTE)
                    mode_next = qat_pkg::M_COOKED;
                else if (qat_pkg::is_blank(byte_in) || byte_in == qat_pkg::CH_BS)
                begin
                    // a lone backspace between tokens gives an empty token
                    n         = 2'd1;
                    k0        = qat_pkg::K_TOKEN_END;
                    mode_next = qat_pkg::M_BETWEEN;
                end
                else
                begin
                    n   = 2'd1;
                    ch0 = byte_in;
                end
            end
        end
    end

    assign total = qat_pkg::clamp_total(cnt_emit);

    always_comb
    begin
        step.count             = n;
        step.r0.kind           = k0;
        step.r0.char_out       = ch0;
        step.r0.token_total    = total;
        step.r0.last           = (n == 2'd1);
        step.r1.kind           = k1;
        step.r1.char_out       = ch1;
        step.r1.token_total    = total;
        step.r1.last           = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= qat_pkg::M_BETWEEN;
            cnt_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && byte_in == qat_pkg::CH_NUL |=> mode_reg == qat_pkg::M_BETWEEN && cnt_reg == '0)
        else $error("scanner not cleared after end of string");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && byte_in != qat_pkg::CH_NUL |=> cnt_reg >= $past(cnt_reg))
        else $error("token count went down inside a string");

    a_pair_source: assert property (@(posedge clk) disable iff (!rst_n)
        step.count == 2'd2 |-> mode_reg == qat_pkg::M_TOKEN || mode_reg == qat_pkg::M_TOKEN_ESC
                               || mode_reg == qat_pkg::M_RAW_ESC)
        else $error("two results from an unexpected scan mode");
`endif

endmodule

// ===== sv/qat_queue.sv =====
// ----------------------------------------------------------------------------
// qat_queue: result queue
// Small register queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module qat_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qat_pkg::step_t      step,
    output logic                room,
    qat_res_if.source           res
);

    qat_pkg::res_t                mem [qat_pkg::Q_DEPTH];
    logic [qat_pkg::Q_PTR_W-1:0]  wr_reg;
    logic [qat_pkg::Q_PTR_W-1:0]  rd_reg;
    logic [qat_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic [qat_pkg::Q_CNT_W-1:0]  cnt_next;
    logic [1:0]                   n_push;
    logic                         pop;
    logic [qat_pkg::Q_PTR_W-1:0]  wr_plus1;

    assign n_push   = push ? step.count : 2'd0;
    assign pop      = res.valid && res.ready;
    assign wr_plus1 = wr_reg + qat_pkg::Q_PTR_W'(1);
    // room for a pair regardless of a transfer this cycle
    assign room     = cnt_reg <= qat_pkg::Q_CNT_W'(qat_pkg::Q_DEPTH - 2);
    assign cnt_next = cnt_reg + qat_pkg::Q_CNT_W'(n_push) - qat_pkg::Q_CNT_W'(pop);

    assign res.valid       = cnt_reg != '0;
    assign res.kind        = mem[rd_reg].kind;
    assign res.char_out    = mem[rd_reg].char_out;
    assign res.token_total = mem[rd_reg].token_total;
    assign res.last        = mem[rd_reg].last;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_reg] <= step.r0;
        if (n_push == 2'd2)
            mem[wr_plus1] <= step.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + qat_pkg::Q_PTR_W'(n_push);
            rd_reg  <= rd_reg + qat_pkg::Q_PTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= qat_pkg::Q_CNT_W'(qat_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("results pushed without room");
`endif

endmodule

// ===== sv/quoted_argument_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer: shell-style argument splitter
// A transferred byte is held in byte_reg until the result queue has room for a
// pair; it is then decoded and its results are written into the queue.
// Throughput: one byte per cycle while the queue has room for a pair; a byte
// with two results takes a second output transfer, absorbed by the four-entry result queue.
// Reset: asynchronous, active low; scanner between tokens, count zero, queue
// empty.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    qat_byte_if.sink    cmd,
    qat_res_if.source   token
);

    logic           valid_reg;
    logic [7:0]     byte_reg;
    logic           room;
    logic           fire;
    qat_pkg::step_t step;

    // decode the held byte once the queue can take a pair
    assign fire      = valid_reg && room;
    assign cmd.ready = !valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.ready)
            valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
            byte_reg <= cmd.byte_in;
    end

    qat_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (byte_reg),
        .step    (step)
    );

    qat_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .step  (step),
        .room  (room),
        .res   (token)
    );

endmodule
